/* rtl/trcf_pkg.sv */
// ----------------------------------------------------------------------------
// trcf_pkg - shared types and constants for the three-ring clock face renderer
// Beat layouts, ring geometry, marker colours and the marker lookup functions.
// ----------------------------------------------------------------------------
package trcf_pkg;

	// ring geometry, in LED positions along the chain
	localparam logic [6:0] OUTER_SIZE  = 7'd60;
	localparam logic [6:0] MIDDLE_SIZE = 7'd24;
	localparam logic [6:0] INNER_SIZE  = 7'd12;
	localparam logic [6:0] MIDDLE_BASE = OUTER_SIZE;
	localparam logic [6:0] INNER_BASE  = OUTER_SIZE + MIDDLE_SIZE;
	localparam logic [6:0] CHAIN_SIZE  = OUTER_SIZE + MIDDLE_SIZE + INNER_SIZE;

	// colours, 0xRRGGBB
	localparam logic [23:0] COL_HOUR_PEAK = 24'hFF0000;
	localparam logic [23:0] COL_HOUR_NEAR = 24'h440000;
	localparam logic [23:0] COL_HOUR_EDGE = 24'h110000;
	localparam logic [23:0] COL_MIN_PEAK  = 24'h00FF00;
	localparam logic [23:0] COL_MIN_EDGE  = 24'h002200;
	localparam logic [23:0] COL_SECOND    = 24'h0000FF;
	localparam logic [23:0] COL_FAULT     = 24'hFF00FF;
	localparam logic [23:0] COL_DARK      = 24'h000000;

	// one request beat
	typedef struct packed {
		logic       show_second;
		logic       time_valid;
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [6:0] pixel_index;
	} item_t;

	// one result beat
	typedef struct packed {
		logic        keep_previous;
		logic [23:0] pixel_color;
	} result_t;

	// five-LED hour marker, offset 0 is the trailing edge
	function automatic logic [23:0] hour_marker(input logic [2:0] d);
		logic [23:0] c;
		case (d)
			3'd0: c = COL_HOUR_EDGE;
			3'd1: c = COL_HOUR_NEAR;
			3'd2: c = COL_HOUR_PEAK;
			3'd3: c = COL_HOUR_NEAR;
			3'd4: c = COL_HOUR_EDGE;
			default: c = COL_DARK;
		endcase
		return c;
	endfunction

	// three-LED minute marker
	function automatic logic [23:0] minute_marker(input logic [1:0] d);
		logic [23:0] c;
		case (d)
			2'd0: c = COL_MIN_EDGE;
			2'd1: c = COL_MIN_PEAK;
			2'd2: c = COL_MIN_EDGE;
			default: c = COL_DARK;
		endcase
		return c;
	endfunction

endpackage

/* rtl/trcf_pixel_logic.sv */
// ----------------------------------------------------------------------------
// trcf_pixel_logic - colour of one LED for a given time of day
// Pure combinational: ring decode, marker offsets modulo the ring, colour OR.
// ----------------------------------------------------------------------------
module trcf_pixel_logic (
	input  trcf_pkg::item_t   item,
	output trcf_pkg::result_t result
);

	logic [3:0] h;
	logic [5:0] m;
	logic [5:0] s;
	logic [5:0] h5;
	logic [6:0] t_hr;
	logic [6:0] d_hr;
	logic [6:0] t_min;
	logic [6:0] d_min;
	logic [6:0] j7;
	logic [5:0] t_mid;
	logic [5:0] d_mid;
	logic [6:0] k7;
	logic [23:0] outer_col;

	always_comb begin
		// hour mod 12 over 0..31
		if (item.hour >= 5'd24)
			h = 4'(item.hour - 5'd24);
		else if (item.hour >= 5'd12)
			h = 4'(item.hour - 5'd12);
		else
			h = 4'(item.hour);

		m = (item.minute >= 6'd60) ? item.minute - 6'd60 : item.minute;
		s = (item.second >= 6'd60) ? item.second - 6'd60 : item.second;

		// hour marker offset: (idx - 5h + 2) mod 60, biased to stay positive
		h5    = {h, 2'b00} + {2'b00, h};
		t_hr  = item.pixel_index + 7'd62 - {1'b0, h5};
		if (t_hr >= 7'd120)
			d_hr = t_hr - 7'd120;
		else if (t_hr >= 7'd60)
			d_hr = t_hr - 7'd60;
		else
			d_hr = t_hr;

		// minute marker offset: (idx - m + 1) mod 60
		t_min = item.pixel_index + 7'd61 - {1'b0, m};
		if (t_min >= 7'd120)
			d_min = t_min - 7'd120;
		else if (t_min >= 7'd60)
			d_min = t_min - 7'd60;
		else
			d_min = t_min;

		outer_col = trcf_pkg::COL_DARK;
		if (d_hr < 7'd5)
			outer_col = outer_col | trcf_pkg::hour_marker(d_hr[2:0]);
		if (d_min < 7'd3)
			outer_col = outer_col | trcf_pkg::minute_marker(d_min[1:0]);
		if (item.show_second && (item.pixel_index == {1'b0, s}))
			outer_col = outer_col | trcf_pkg::COL_SECOND;

		// middle ring offset: (j - 2h + 1) mod 24, biased sum spans 3..48
		j7    = item.pixel_index - trcf_pkg::MIDDLE_BASE;
		t_mid = {1'b0, j7[4:0]} + 6'd25 - {1'b0, h, 1'b0};
		if (t_mid >= 6'd48)
			d_mid = t_mid - 6'd48;
		else if (t_mid >= 6'd24)
			d_mid = t_mid - 6'd24;
		else
			d_mid = t_mid;

		k7 = item.pixel_index - trcf_pkg::INNER_BASE;

		result.pixel_color   = trcf_pkg::COL_DARK;
		result.keep_previous = 1'b0;
		if (item.pixel_index >= trcf_pkg::CHAIN_SIZE) begin
			result.pixel_color = trcf_pkg::COL_DARK;
		end else if (!item.time_valid) begin
			if (item.pixel_index < trcf_pkg::OUTER_SIZE)
				result.pixel_color = trcf_pkg::COL_FAULT;
			else
				result.keep_previous = 1'b1;
		end else if (item.pixel_index < trcf_pkg::OUTER_SIZE) begin
			result.pixel_color = outer_col;
		end else if (item.pixel_index < trcf_pkg::INNER_BASE) begin
			if (d_mid < 6'd2)
				result.pixel_color = trcf_pkg::COL_HOUR_NEAR;
		end else begin
			if (k7[3:0] == h)
				result.pixel_color = trcf_pkg::COL_HOUR_EDGE;
		end
	end

endmodule

/* rtl/three_ring_clock_face_renderer.sv */
// ----------------------------------------------------------------------------
// three_ring_clock_face_renderer - LED colour for a 60/24/12 ring clock face
// Registered request, single-pass colour logic, registered result beat.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream (s_axis_*) takes one request beat per LED: the LED index in
//    the 96-LED chain and the time of day, with the time-valid and
//    show-seconds flags in tuser.
//  - Master stream (m_axis_*) returns one beat per request, in order: the
//    0xRRGGBB colour in tdata and the keep-previous flag in tuser.
//  - One input register, then the colour logic into the result register;
//    m_axis_tvalid rises when the result register loads the beat.
//  - Throughput is one beat per cycle while m_axis_tready stays high; each
//    beat is independent of the rest.
//  - While the receiver stalls the result register holds and the input
//    register fills behind it; s_axis_tready drops only when both are full.
//    Ready propagates combinationally backwards through the two stages.
//  - Reset (arst_n low) empties both stages at once; no beat is in flight
//    afterwards and the block is ready straight away. No clearing pass.
//  - Invalid time paints the outer ring magenta and asks the middle and inner
//    rings to keep their previous colour (pixel_color then reads zero).
//  - Indices beyond the chain give a dark colour.
// ----------------------------------------------------------------------------
module three_ring_clock_face_renderer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata, from bit 0: pixel_index[6:0], hour[4:0], minute[5:0], second[5:0]
	input  logic [23:0] s_axis_tdata,
	// tuser, from bit 0: time_valid, show_second
	input  logic [1:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata, from bit 0: pixel_color[23:0]
	output logic [23:0] m_axis_tdata,
	// tuser, from bit 0: keep_previous
	output logic [0:0]  m_axis_tuser
);

	trcf_pkg::item_t   item_in;
	trcf_pkg::item_t   item_s1;
	trcf_pkg::result_t res_comb;
	trcf_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              adv_s2;
	logic              load_s1;

	// unpack the request beat
	assign item_in.pixel_index = s_axis_tdata[6:0];
	assign item_in.hour        = s_axis_tdata[11:7];
	assign item_in.minute      = s_axis_tdata[17:12];
	assign item_in.second      = s_axis_tdata[23:18];
	assign item_in.time_valid  = s_axis_tuser[0];
	assign item_in.show_second = s_axis_tuser[1];

	// result stage moves when empty or when its beat is taken
	assign adv_s2        = !valid_s2 || m_axis_tready;
	// input stage can take a beat when empty or when it hands over
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign load_s1       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (load_s1)
			item_s1 <= item_in;
		if (adv_s2 && valid_s1)
			res_s2 <= res_comb;
	end

	trcf_pixel_logic u_pixel (
		.item   (item_s1),
		.result (res_comb)
	);

	assign m_axis_tvalid   = valid_s2;
	assign m_axis_tdata    = res_s2.pixel_color;
	assign m_axis_tuser[0] = res_s2.keep_previous;

`ifndef SYNTHESIS
	// a taking receiver always frees room for a new request
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input not ready although output is being drained");

	// keep-previous beats carry a dark colour
	a_keep_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == trcf_pkg::COL_DARK)
		else $error("keep_previous beat with non-zero colour");

	// beyond the chain: dark and no keep
	a_beyond_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && (item_s1.pixel_index >= trcf_pkg::CHAIN_SIZE)
		|=> m_axis_tvalid && m_axis_tdata == trcf_pkg::COL_DARK && !m_axis_tuser[0])
		else $error("index beyond chain not rendered dark");

	// fault display on the outer ring
	a_outer_fault: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && !item_s1.time_valid
		&& (item_s1.pixel_index < trcf_pkg::OUTER_SIZE)
		|=> m_axis_tdata == trcf_pkg::COL_FAULT && !m_axis_tuser[0])
		else $error("outer ring fault colour missing");
`endif

endmodule
